FILE: src/nvae_pkg.sv
package nvae_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int VALUE_BITS  = 16;
    localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic signed [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS:0]   sum_out;
        logic signed [VALUE_BITS-1:0] nearest;
        t_status                      status;
    } t_out_item;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_scan_ctl;

endpackage

FILE: src/nvae_ram.sv
module nvae_ram #(
    parameter int DEPTH     = 16384,
    parameter int WIDTH     = 16,
    parameter int ADDR_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: src/nvae_scan.sv
module nvae_scan (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  nvae_pkg::t_scan_ctl                      i_ctl,
    input  logic signed [nvae_pkg::VALUE_BITS-1:0]   i_data,
    input  logic signed [nvae_pkg::VALUE_BITS-1:0]   i_query,
    output logic                                     o_done,
    output logic signed [nvae_pkg::VALUE_BITS-1:0]   o_best
);

    logic signed [nvae_pkg::VALUE_BITS:0]   w_diff;
    logic        [nvae_pkg::VALUE_BITS-1:0] w_mag;
    logic        [nvae_pkg::VALUE_BITS-1:0] r_best_diff;

    assign w_diff = $signed({i_data[nvae_pkg::VALUE_BITS-1], i_data})
                  - $signed({i_query[nvae_pkg::VALUE_BITS-1], i_query});
    assign w_mag  = w_diff[nvae_pkg::VALUE_BITS] ? nvae_pkg::VALUE_BITS'(-w_diff)
                                                 : w_diff[nvae_pkg::VALUE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_ctl.vld && i_ctl.last;
        end
        if (i_ctl.vld && (i_ctl.first || (w_mag < r_best_diff))) begin
            r_best_diff <= w_mag;
            o_best      <= i_data;
        end
    end

endmodule

FILE: src/nearest_value_add_engine.sv
// Nearest value search over a table of signed reference values.
// Input channel (i_in_valid / o_in_stall / i_in_item): clear, load or query.
// Output channel (o_out_valid / i_out_stall / o_out_item): one result per load
// and per query; clear and the unused request code give none.
// A load writes the next free table entry; its result goes from r_res to the
// output register in S_PUSH. A load into a full table is dropped with status
// full. A query reads the N filled entries one per cycle from the table
// memory's single read port and keeps the first entry with the smallest
// distance; a query on an empty table gives status empty without a scan.
// One item is in work at a time: o_in_stall is high from the transfer until
// the result is in the output register. The output register holds a result
// while i_out_stall is high; the next item is taken as soon as its
// predecessor's result is registered.
// Reset empties the table and drops a pending result; table contents are
// not cleared and are never read before being written.
module nearest_value_add_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  nvae_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nvae_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH
    } t_state;

    t_state                                   r_state;
    logic [nvae_pkg::CNT_BITS-1:0]            r_count;
    logic [nvae_pkg::CNT_BITS-1:0]            r_idx;
    logic signed [nvae_pkg::VALUE_BITS-1:0]   r_query;
    nvae_pkg::t_out_item                      r_res;
    nvae_pkg::t_scan_ctl                      r_ctl;

    logic                                     w_accept;
    logic                                     w_full;
    logic                                     w_wr_en;
    logic                                     w_rd_en;
    logic [nvae_pkg::VALUE_BITS-1:0]          w_rd_data;
    logic                                     w_done;
    logic signed [nvae_pkg::VALUE_BITS-1:0]   w_best;
    logic signed [nvae_pkg::VALUE_BITS:0]     w_sum;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_full     = (r_count == nvae_pkg::CNT_BITS'(nvae_pkg::TABLE_DEPTH));
    assign w_wr_en    = w_accept && (i_in_item.req_type == nvae_pkg::REQ_LOAD) && !w_full;
    assign w_rd_en    = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_sum      = $signed({r_query[nvae_pkg::VALUE_BITS-1], r_query})
                      + $signed({w_best[nvae_pkg::VALUE_BITS-1], w_best});

    nvae_ram #(
        .DEPTH     (nvae_pkg::TABLE_DEPTH),
        .WIDTH     (nvae_pkg::VALUE_BITS),
        .ADDR_BITS (nvae_pkg::ADDR_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[nvae_pkg::ADDR_BITS-1:0]),
        .i_wr_data (i_in_item.value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[nvae_pkg::ADDR_BITS-1:0]),
        .o_rd_data (w_rd_data)
    );

    nvae_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_data  ($signed(w_rd_data)),
        .i_query (r_query),
        .o_done  (w_done),
        .o_best  (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ctl       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_ctl.vld   <= w_rd_en;
            r_ctl.first <= (r_idx == '0);
            r_ctl.last  <= ((r_idx + nvae_pkg::CNT_BITS'(1)) == r_count);
            if (o_out_valid && !i_out_stall && (r_state != S_PUSH)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_in_item.req_type)
                            nvae_pkg::REQ_CLEAR: begin
                                r_count <= '0;
                            end
                            nvae_pkg::REQ_LOAD: begin
                                r_res.sum_out <= '0;
                                r_res.nearest <= '0;
                                if (w_full) begin
                                    r_res.status <= nvae_pkg::ST_FULL;
                                end else begin
                                    r_res.status <= nvae_pkg::ST_OK;
                                    r_count      <= r_count + nvae_pkg::CNT_BITS'(1);
                                end
                                r_state <= S_PUSH;
                            end
                            nvae_pkg::REQ_QUERY: begin
                                if (r_count == '0) begin
                                    r_res.sum_out <= '0;
                                    r_res.nearest <= '0;
                                    r_res.status  <= nvae_pkg::ST_EMPTY;
                                    r_state       <= S_PUSH;
                                end else begin
                                    r_query <= i_in_item.value;
                                    r_idx   <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_rd_en) begin
                        r_idx <= r_idx + nvae_pkg::CNT_BITS'(1);
                    end
                    if (w_done) begin
                        r_res.sum_out <= w_sum;
                        r_res.nearest <= w_best;
                        r_res.status  <= nvae_pkg::ST_OK;
                        r_state       <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b1;
                        o_out_item  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index beyond fill count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nvae_pkg::CNT_BITS'(nvae_pkg::TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.vld |-> (r_state == S_SCAN))
        else $error("table read data outside a scan");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("fill count changed during a scan");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         FILL_MAX   = 48;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    nvae_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    nvae_pkg::t_out_item o_out_item;

    logic signed [nvae_pkg::VALUE_BITS-1:0] table_copy [nvae_pkg::TABLE_DEPTH];
    int                  table_fill     = 0;
    nvae_pkg::t_out_item pending_results [$];
    int                  mismatch_count = 0;
    int                  in_gap_max     = 0;
    int                  out_stall_max  = 0;

    nearest_value_add_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    task automatic predict_nearest(nvae_pkg::t_in_item it);
        int                  qv;
        int                  best;
        int                  best_dist;
        int                  cur_dist;
        nvae_pkg::t_out_item r;
        r        = '0;
        r.status = nvae_pkg::ST_OK;
        qv       = $signed(it.value);
        case (it.req_type)
            nvae_pkg::REQ_CLEAR: begin
                table_fill = 0;
            end
            nvae_pkg::REQ_LOAD: begin
                if (table_fill >= nvae_pkg::TABLE_DEPTH) begin
                    r.status = nvae_pkg::ST_FULL;
                end else begin
                    table_copy[table_fill] = it.value;
                    table_fill++;
                end
                pending_results.push_back(r);
            end
            nvae_pkg::REQ_QUERY: begin
                if (table_fill == 0) begin
                    r.status = nvae_pkg::ST_EMPTY;
                end else begin
                    best      = table_copy[0];
                    best_dist = (best >= qv) ? best - qv : qv - best;
                    for (int k = 1; k < table_fill; k++) begin
                        cur_dist = (table_copy[k] >= qv) ? table_copy[k] - qv
                                                         : qv - table_copy[k];
                        if (cur_dist < best_dist) begin
                            best_dist = cur_dist;
                            best      = table_copy[k];
                        end
                    end
                    r.sum_out = (nvae_pkg::VALUE_BITS + 1)'(qv + best);
                    r.nearest = nvae_pkg::VALUE_BITS'(best);
                end
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(logic [1:0] req, logic signed [nvae_pkg::VALUE_BITS-1:0] val);
        int                 gap;
        nvae_pkg::t_in_item it;
        gap         = $urandom_range(0, in_gap_max);
        it.req_type = req;
        it.value    = val;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_nearest(it);
    endtask

    function automatic logic signed [nvae_pkg::VALUE_BITS-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: rand_value = {1'b1, {(nvae_pkg::VALUE_BITS - 1){1'b0}}};
            1: rand_value = {1'b0, {(nvae_pkg::VALUE_BITS - 1){1'b1}}};
            2: rand_value = nvae_pkg::VALUE_BITS'(int'($urandom_range(0, 64)) - 32);
            default: rand_value = nvae_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        in_gap_max    = 3;
        out_stall_max = 3;
        send_item(nvae_pkg::REQ_QUERY, 16'sd7);
        send_item(nvae_pkg::REQ_LOAD, -16'sd32768);
        send_item(nvae_pkg::REQ_LOAD, 16'sd32767);
        send_item(nvae_pkg::REQ_LOAD, 16'sd0);
        send_item(nvae_pkg::REQ_QUERY, 16'sd32767);
        send_item(nvae_pkg::REQ_QUERY, -16'sd32768);
        send_item(nvae_pkg::REQ_QUERY, 16'sd1);
        send_item(REQ_UNUSED, -16'sd1);
        send_item(nvae_pkg::REQ_QUERY, -16'sd1);
        send_item(nvae_pkg::REQ_CLEAR, 16'sh5555);
        send_item(nvae_pkg::REQ_QUERY, 16'shAAAA);
        send_item(nvae_pkg::REQ_LOAD, 16'sd10);
        send_item(nvae_pkg::REQ_LOAD, 16'sd20);
        send_item(nvae_pkg::REQ_QUERY, 16'sd15);
        send_item(nvae_pkg::REQ_LOAD, 16'sd10);
        send_item(nvae_pkg::REQ_QUERY, 16'sd10);
        send_item(nvae_pkg::REQ_LOAD, -16'sd5);
        send_item(nvae_pkg::REQ_QUERY, -16'sd32768);
        send_item(nvae_pkg::REQ_QUERY, 16'sd32767);
        send_item(nvae_pkg::REQ_QUERY, 16'sd2);
        send_item(nvae_pkg::REQ_CLEAR, 16'sd0);
    endtask

    task automatic test_random();
        int pick;
        int a;
        int b;
        for (int phase = 0; phase < 4; phase++) begin
            in_gap_max    = phase[0] ? 16 : 0;
            out_stall_max = phase[1] ? 16 : 0;
            repeat (20) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_item(nvae_pkg::REQ_CLEAR, rand_value());
                end else if (pick < 7) begin
                    send_item(REQ_UNUSED, rand_value());
                end else if (pick < 50) begin
                    if (table_fill >= FILL_MAX)
                        send_item(nvae_pkg::REQ_CLEAR, rand_value());
                    else
                        send_item(nvae_pkg::REQ_LOAD, rand_value());
                end else if (table_fill >= 2 && pick < 70) begin
                    a = table_copy[$urandom_range(0, table_fill - 1)];
                    b = table_copy[$urandom_range(0, table_fill - 1)];
                    if (((a + b) % 2) == 0)
                        send_item(nvae_pkg::REQ_QUERY, nvae_pkg::VALUE_BITS'((a + b) / 2));
                    else
                        send_item(nvae_pkg::REQ_QUERY, nvae_pkg::VALUE_BITS'(a));
                end else begin
                    send_item(nvae_pkg::REQ_QUERY, rand_value());
                end
            end
        end
    endtask

    initial begin
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = $urandom_range(0, out_stall_max);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        nvae_pkg::t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: %p", o_out_item);
                mismatch_count++;
            end else begin
                exp_item = pending_results.pop_front();
                if (o_out_item.sum_out !== exp_item.sum_out) begin
                    $error("sum_out expected %0d actual %0d", exp_item.sum_out,
                           o_out_item.sum_out);
                    mismatch_count++;
                end
                if (o_out_item.nearest !== exp_item.nearest) begin
                    $error("nearest expected %0d actual %0d", exp_item.nearest,
                           o_out_item.nearest);
                    mismatch_count++;
                end
                if (o_out_item.status !== exp_item.status) begin
                    $error("status expected %0d actual %0d", exp_item.status,
                           o_out_item.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: nearest_value_add_engine.f
src/nvae_pkg.sv
src/nvae_ram.sv
src/nvae_scan.sv
src/nearest_value_add_engine.sv
verif/tb_top.sv
